FILE: sv/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Used by bsa_ctrl, the top level and the testbench; depends on nothing.
`default_nettype none

package bsa_pkg;

  localparam int MAX_SLOTS_DEF      = 1024;
  localparam int SLOTS_PER_WORD_DEF = 8;

  localparam int COUNT_W  = 11;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/bsa_map_ram.sv
// Single-port-write, single-port-read synchronous memory holding the slot bitmap.
// Read data is registered and holds while no read is issued.
`default_nettype none

module bsa_map_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 8,
  parameter int AW    = 7
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/bsa_word_pick.sv
// Finds the lowest free slot in one bitmap word that lies below the slot count.
// Purely combinational; used by the allocator controller.
`default_nettype none

module bsa_word_pick #(
  parameter int SPW    = 8,
  parameter int BASE_W = 11,
  parameter int CNT_W  = 11,
  parameter int BIT_W  = 3
) (
  input  wire logic [SPW-1:0]    word,
  input  wire logic [BASE_W-1:0] base,
  input  wire logic [CNT_W-1:0]  count,
  output logic                   hit,
  output logic      [BIT_W-1:0]  bit_idx,
  output logic      [SPW-1:0]    set_word
);

  logic [SPW-1:0] usable;
  logic [SPW-1:0] avail;
  logic [SPW-1:0] lowest;

  always_comb begin
    for (int i = 0; i < SPW; i++) begin
      usable[i] = (32'(base) + 32'(i)) < 32'(count);
    end
  end

  assign avail  = usable & ~word;
  // Two's-complement trick isolates the lowest set bit.
  assign lowest = avail & (~avail + SPW'(1));
  assign hit    = |avail;

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < SPW; i++) begin
      if (lowest[i]) begin
        bit_idx = bit_idx | BIT_W'(i);
      end
    end
  end

  assign set_word = word | lowest;

endmodule

`default_nettype wire

FILE: sv/bsa_ctrl.sv
// Request sequencer of the slot allocator: clearing pass, word-by-word scan,
// read-modify-write of the bitmap and the result register. Uses bsa_pkg,
// bsa_map_ram and bsa_word_pick.
`default_nettype none

module bsa_ctrl #(
  parameter int MAX_SLOTS      = bsa_pkg::MAX_SLOTS_DEF,
  parameter int SLOTS_PER_WORD = bsa_pkg::SLOTS_PER_WORD_DEF,
  parameter int CNT_W          = $clog2(MAX_SLOTS + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [CNT_W-1:0]             count,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_kind,
  input  wire logic [bsa_pkg::INDEX_W-1:0]  in_slot_index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bsa_pkg::INDEX_W-1:0]  out_granted_slot,
  output logic      [bsa_pkg::STATUS_W-1:0] out_status
);

  import bsa_pkg::*;

  // Slots per word must be a power of two so a slot splits into word and bit by a shift.
  localparam int WORD_COUNT = (MAX_SLOTS + SLOTS_PER_WORD - 1) / SLOTS_PER_WORD;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(SLOTS_PER_WORD);
  localparam int BASE_W     = $clog2(MAX_SLOTS + SLOTS_PER_WORD + 1);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       eval_w_r, eval_w_nxt;
  logic [BASE_W-1:0]   eval_base_r, eval_base_nxt;
  logic [AW-1:0]       clr_w_r, clr_w_nxt;
  logic [INDEX_W-1:0]  idx_r, idx_nxt;
  logic                range_r, range_nxt;
  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_slot_r;
  status_t             out_status_r;

  logic                      mem_rd_en;
  logic [AW-1:0]             mem_rd_addr;
  logic [SLOTS_PER_WORD-1:0] mem_rd_data;
  logic                      mem_wr_en;
  logic [AW-1:0]             mem_wr_addr;
  logic [SLOTS_PER_WORD-1:0] mem_wr_data;

  logic                      pick_hit;
  logic [BIT_W-1:0]          pick_bit;
  logic [SLOTS_PER_WORD-1:0] pick_word;

  logic                      accept;
  logic                      out_free;
  logic                      scan_end;
  logic                      scan_stall;
  logic                      in_range_bad;
  logic [SLOTS_PER_WORD-1:0] free_mask;
  logic                      res_load;
  logic [INDEX_W-1:0]        res_slot;
  status_t                   res_status;

  bsa_map_ram #(
    .DEPTH (WORD_COUNT),
    .WIDTH (SLOTS_PER_WORD),
    .AW    (AW)
  ) u_map_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  bsa_word_pick #(
    .SPW    (SLOTS_PER_WORD),
    .BASE_W (BASE_W),
    .CNT_W  (CNT_W),
    .BIT_W  (BIT_W)
  ) u_word_pick (
    .word     (mem_rd_data),
    .base     (eval_base_r),
    .count    (count),
    .hit      (pick_hit),
    .bit_idx  (pick_bit),
    .set_word (pick_word)
  );

  assign in_ready     = (state_r == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign in_range_bad = 32'(in_slot_index) >= 32'(count);
  // Without a hit, the scan stops at the last word of the memory or the last word holding slots in use.
  assign scan_end     = (eval_w_r == AW'(WORD_COUNT - 1)) ||
                        ((32'(eval_base_r) + 32'(SLOTS_PER_WORD)) >= 32'(count));
  assign scan_stall   = (state_r == ST_SCAN) && (pick_hit || scan_end) && !out_free;
  assign free_mask    = SLOTS_PER_WORD'(1) << idx_r[BIT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_w_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_w_r <= clr_w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eval_w_r    <= eval_w_nxt;
    eval_base_r <= eval_base_nxt;
    idx_r       <= idx_nxt;
    range_r     <= range_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    eval_w_nxt    = eval_w_r;
    eval_base_nxt = eval_base_r;
    clr_w_nxt     = clr_w_r;
    idx_nxt       = idx_r;
    range_nxt     = range_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = '0;
    mem_wr_data   = '0;
    res_load      = 1'b0;
    res_slot      = '0;
    res_status    = STATUS_OK;

    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_w_r;
        clr_w_nxt   = clr_w_r + AW'(1);
        if (clr_w_r == AW'(WORD_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_ALLOC) begin
            mem_rd_en     = 1'b1;
            mem_rd_addr   = '0;
            eval_w_nxt    = '0;
            eval_base_nxt = '0;
            state_nxt     = ST_SCAN;
          end else begin
            idx_nxt     = in_slot_index;
            range_nxt   = in_range_bad;
            mem_rd_en   = !in_range_bad;
            mem_rd_addr = AW'(in_slot_index >> BIT_W);
            state_nxt   = ST_FREE;
          end
        end
      end
      ST_SCAN: begin
        if (pick_hit || scan_end) begin
          if (out_free) begin
            res_load = 1'b1;
            if (pick_hit) begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = eval_w_r;
              mem_wr_data = pick_word;
              res_slot    = INDEX_W'(eval_base_r + BASE_W'(pick_bit));
              res_status  = STATUS_OK;
            end else begin
              res_status = STATUS_FULL;
            end
            state_nxt = ST_IDLE;
          end
        end else begin
          mem_rd_en     = 1'b1;
          mem_rd_addr   = eval_w_r + AW'(1);
          eval_w_nxt    = eval_w_r + AW'(1);
          eval_base_nxt = eval_base_r + BASE_W'(SLOTS_PER_WORD);
        end
      end
      ST_FREE: begin
        if (out_free) begin
          res_load = 1'b1;
          if (range_r) begin
            res_status = STATUS_RANGE;
          end else begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(idx_r >> BIT_W);
            mem_wr_data = mem_rd_data & ~free_mask;
            res_status  = STATUS_OK;
          end
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_slot_r   <= res_slot;
      out_status_r <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> !accept)
    else $error("bitmap write coincides with a new request");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    scan_stall |=> $stable(mem_rd_data))
    else $error("bitmap word changed while the scan was stalled");

  a_base_tracks_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (32'(eval_base_r) == 32'(eval_w_r) * SLOTS_PER_WORD))
    else $error("scan base slot out of step with word address");

  a_grant_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && (state_r == ST_SCAN) && (res_status == STATUS_OK)) |->
      (32'(res_slot) < 32'(count)))
    else $error("granted slot lies at or beyond the slot count");

endmodule

`default_nettype wire

FILE: sv/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: slot count register and the request
// sequencer. Depends on bsa_pkg and bsa_ctrl.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_kind, in_slot_index
//   out      output     out_valid / out_ready  out_granted_slot, out_status
//   cfg      input      cfg_we                 cfg_wdata (slot count)
//
// An allocate holds the block while it examines bitmap words, one word per cycle
// through the single read port, up to every word of the bitmap.
// A release holds it through one read and one write-back.
// After reset a clearing pass writes every bitmap word (128 by default) with in_ready
// low; configuration writes are taken throughout.
// A result waiting in the output register does not block the next request; only its
// completion waits for the output register to empty.
`default_nettype none

module bitmap_slot_allocator #(
  parameter int MAX_SLOTS      = bsa_pkg::MAX_SLOTS_DEF,
  parameter int SLOTS_PER_WORD = bsa_pkg::SLOTS_PER_WORD_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [bsa_pkg::COUNT_W-1:0]  cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_kind,
  input  wire logic [bsa_pkg::INDEX_W-1:0]  in_slot_index,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bsa_pkg::INDEX_W-1:0]  out_granted_slot,
  output logic      [bsa_pkg::STATUS_W-1:0] out_status
);

  import bsa_pkg::*;

  localparam int CNT_W = $clog2(MAX_SLOTS + 1);

  logic [COUNT_W-1:0] slot_count_r;
  logic [CNT_W-1:0]   count_in_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_COUNT_RST;
    end else if (cfg_we) begin
      slot_count_r <= cfg_wdata;
    end
  end

  // A count above the built capacity acts as the capacity.
  always_comb begin
    if (32'(slot_count_r) > 32'(MAX_SLOTS)) begin
      count_in_use = CNT_W'(MAX_SLOTS);
    end else begin
      count_in_use = CNT_W'(slot_count_r);
    end
  end

  bsa_ctrl #(
    .MAX_SLOTS      (MAX_SLOTS),
    .SLOTS_PER_WORD (SLOTS_PER_WORD),
    .CNT_W          (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .count            (count_in_use),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

FILE: test/bitmap_slot_allocator_tb.sv
// Self-checking testbench for bitmap_slot_allocator: predicts every grant and release
// outcome from its own copy of the slot bitmap and checks each result in order.
// Depends on bsa_pkg and the bitmap_slot_allocator RTL.
module bitmap_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam int MAX_SLOTS = MAX_SLOTS_DEF;
  localparam int WORD_BITS = SLOTS_PER_WORD_DEF;
  localparam int WORDS     = MAX_SLOTS / WORD_BITS;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] slot_index;
  } request_t;

  typedef struct packed {
    logic [INDEX_W-1:0] granted_slot;
    status_t            status;
  } outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_kind = KIND_ALLOC;
  logic [INDEX_W-1:0]  in_slot_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [INDEX_W-1:0]  out_granted_slot;
  logic [STATUS_W-1:0] out_status;

  request_t request_queue[$];
  outcome_t pending_grants[$];

  // Model of the block: one bit per slot, 1 meaning taken, and the slot count register.
  logic [WORD_BITS-1:0] taken_map[WORDS];
  int unsigned          slot_limit = SLOT_COUNT_RST;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;

  int requests_sent = 0;
  int results_seen = 0;
  int fail_count = 0;
  int grants_ok = 0;
  int full_seen = 0;
  int range_seen = 0;
  int settings_written = 0;

  bitmap_slot_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Works out the result of one request and updates the bitmap as the block would.
  function automatic outcome_t grant_outcome(logic kind, logic [INDEX_W-1:0] idx);
    outcome_t             res;
    int unsigned          in_use;
    int unsigned          first;
    logic [WORD_BITS-1:0] usable;
    logic [WORD_BITS-1:0] avail;
    bit                   found;
    res.granted_slot = '0;
    res.status = STATUS_FULL;
    in_use = (slot_limit > MAX_SLOTS) ? MAX_SLOTS : slot_limit;
    found = 1'b0;
    if (kind == KIND_ALLOC) begin
      for (int w = 0; w < WORDS && !found; w++) begin
        first = w * WORD_BITS;
        if (first >= in_use) begin
          usable = '0;
        end else if (in_use - first >= WORD_BITS) begin
          usable = '1;
        end else begin
          usable = {WORD_BITS{1'b1}} >> (WORD_BITS - (in_use - first));
        end
        avail = usable & ~taken_map[w];
        for (int b = 0; b < WORD_BITS && !found; b++) begin
          if (avail[b]) begin
            taken_map[w][b] = 1'b1;
            res.granted_slot = INDEX_W'(first + b);
            res.status = STATUS_OK;
            found = 1'b1;
          end
        end
      end
    end else if (idx >= in_use) begin
      res.status = STATUS_RANGE;
    end else begin
      taken_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
      res.status = STATUS_OK;
    end
    return res;
  endfunction

  always @(posedge clk) begin : driver
    request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_grants.push_back(grant_outcome(in_kind, in_slot_index));
      end
      if (!in_valid || in_ready) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = request_queue.pop_front();
          in_valid <= 1'b1;
          in_kind <= req.kind;
          in_slot_index <= req.slot_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The long hold-off is timed here, apart from the random stalls of the receiver.
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    outcome_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_grants.size() == 0) begin
          $error("unexpected result: granted_slot %0d, status %0d",
                 out_granted_slot, out_status);
          fail_count++;
        end else begin
          want = pending_grants.pop_front();
          if (out_granted_slot !== want.granted_slot) begin
            $error("granted_slot: expected %0d, got %0d", want.granted_slot, out_granted_slot);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          case (want.status)
            STATUS_OK:    grants_ok++;
            STATUS_FULL:  full_seen++;
            STATUS_RANGE: range_seen++;
            default: ;
          endcase
        end
      end
      if (hold_start || hold_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic push_request(logic kind, int unsigned idx);
    request_t req;
    req.kind = kind;
    req.slot_index = INDEX_W'(idx);
    request_queue.push_back(req);
    requests_sent++;
  endtask

  // Waits until every request has been taken and answered.
  task automatic drain();
    while (results_seen != requests_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_slot_count(int unsigned value);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= COUNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_limit = value;
    settings_written++;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Mostly releases near the slots in use, so that the bitmap fills and empties;
  // some releases land anywhere in the index range.
  task automatic random_requests(int n, int alloc_pct);
    int unsigned span;
    span = (slot_limit > MAX_SLOTS) ? MAX_SLOTS : slot_limit;
    span = (span + 4 > MAX_SLOTS) ? MAX_SLOTS : span + 4;
    repeat (n) begin
      if ($urandom_range(99) < alloc_pct) begin
        push_request(KIND_ALLOC, $urandom_range(MAX_SLOTS - 1));
      end else if ($urandom_range(99) < 15) begin
        push_request(KIND_FREE, $urandom_range(MAX_SLOTS - 1));
      end else begin
        push_request(KIND_FREE, $urandom_range(span - 1));
      end
    end
  endtask

  initial begin : stimulus
    foreach (taken_map[w]) taken_map[w] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Lowest-first grants, reuse of a released slot, release of a free slot.
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 1023);
    push_request(KIND_FREE, 0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 1023);
    // With no slots in use nothing can be granted or released.
    set_slot_count(0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 0);
    // A partial first word: bits at or above the count stay out of reach.
    set_slot_count(3);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 3);
    push_request(KIND_FREE, 2);
    // A count above capacity behaves as the full capacity.
    set_slot_count(2047);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 1023);
    push_request(KIND_ALLOC, 0);
    // Lowering the count keeps the bits already set above it.
    set_slot_count(1);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 1);
    push_request(KIND_FREE, 0);
    push_request(KIND_ALLOC, 0);

    set_slot_count(1024);
    set_idling(0, 0);
    random_requests(300, 75);

    set_slot_count($urandom_range(1, 64));
    set_idling(66, 0);
    random_requests(200, 60);

    set_slot_count(200);
    set_idling(0, 66);
    random_requests(200, 60);

    set_slot_count($urandom_range(65, 1024));
    set_idling(26, 26);
    random_requests(200, 65);

    // The receiver holds off while requests keep coming, so the block backs up.
    set_slot_count(16);
    set_idling(0, 0);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    random_requests(60, 60);

    set_slot_count(1024);
    set_idling(26, 26);
    random_requests(100, 50);

    drain();
    repeat (200) @(posedge clk);
    if (pending_grants.size() != 0) begin
      $error("%0d expected results never arrived", pending_grants.size());
      fail_count++;
    end
    $display("Checked %0d requests across %0d slot-count settings:", requests_sent,
             settings_written);
    $display("%0d succeeded, %0d found no free slot, %0d were out of range.",
             grants_ok, full_seen, range_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
